// ===== rtl/ftma_pkg.sv =====
// Shared widths, sizes and control types for the frame time averager.
`timescale 1ns / 1ps

package ftma_pkg;

  // Ring of frame means
  localparam int WINDOW_DEPTH = 10;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  // Datapath widths
  localparam int DUR_W  = 32;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 16;
  localparam int MEAN_W = 32;
  localparam int TOT_W  = MEAN_W + IDX_W;

  // Step counter of the shared divider
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Input action codes
  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_FRAME_END = 1'b1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/ftma_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ftma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ftma_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ftma_divider
  import ftma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output div_sts_t         sts
);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              done;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[SUM_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = !trial[CNT_W];
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= !start && (steps == STEP_W'(1));
      if (start) begin
        steps <= STEP_W'(SUM_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
      end
    end
  end

  // Datapath: dividend shifts out of quo as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign quotient = quo;
  assign sts.busy = (steps != '0);
  assign sts.done = done;

endmodule

// ===== rtl/frame_time_moving_average_core.sv =====
// Frame time averager: sample accumulation, ring of frame means, window mean.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  action, duration_ns
//   out      output     out_valid/out_stall window_average_ns, has_time
//
// A sample item is accepted in S_IDLE, and samples may follow back to back. A
// frame-end item stalls the input while it runs two passes of the shared
// divider plus one ring read per filled entry for the window sum. An empty frame
// skips the first pass.
// rst is synchronous; ring contents are not cleared, only the fill count and slot.
// The result sits in an output register; samples are accepted while it waits,
// a finished frame-end result holds until the output register is free.
`timescale 1ns / 1ps

module frame_time_moving_average_core
  import ftma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [DUR_W-1:0]  duration_ns,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MEAN_W-1:0] window_average_ns,
  output logic              has_time
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV1  = 6'b000010,
    S_WRITE = 6'b000100,
    S_SUM   = 6'b001000,
    S_DIV2  = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t            state;
  logic [SUM_W-1:0]  frame_sum;
  logic [CNT_W-1:0]  frame_count;
  logic [FILL_W-1:0] filled;
  logic [IDX_W-1:0]  slot;
  logic [FILL_W-1:0] rd_idx;
  logic              rd_pend;
  logic [TOT_W-1:0]  total;
  logic [MEAN_W-1:0] mean;
  logic [MEAN_W-1:0] avg;

  logic              in_xfer;
  logic              out_xfer;
  logic              load;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_next;

  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [CNT_W-1:0]  div_divisor;
  logic [SUM_W-1:0]  div_quo;
  div_sts_t          div_sts;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [MEAN_W-1:0] ram_rdata;
  logic              ring_full;
  logic              sum_issue;
  logic              sum_finish;

  // Handshake terms
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign load     = (state == S_LOAD) && (!out_valid || !out_stall);

  // Saturating accumulate of a sample
  always_comb begin
    sum_ext  = {1'b0, frame_sum} + (SUM_W + 1)'(duration_ns);
    sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  // Ring bookkeeping and window sum read control
  assign ring_full  = (filled == FILL_W'(WINDOW_DEPTH));
  assign ram_we     = (state == S_WRITE);
  assign ram_waddr  = ring_full ? slot : filled[IDX_W-1:0];
  assign sum_issue  = (state == S_SUM) && (rd_idx != filled);
  assign sum_finish = (state == S_SUM) && (rd_idx == filled) && !rd_pend;

  // Divider operand select: frame mean first, then window mean
  always_comb begin
    div_start    = 1'b0;
    div_dividend = frame_sum;
    div_divisor  = frame_count;
    if (in_xfer && action == ACT_FRAME_END && frame_count != '0) begin
      div_start = 1'b1;
    end else if (sum_finish) begin
      div_start    = 1'b1;
      div_dividend = SUM_W'(total);
      div_divisor  = CNT_W'(filled);
    end
  end

  ftma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  ftma_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (mean),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_sum   <= '0;
      frame_count <= '0;
      filled      <= '0;
      slot        <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // a new result may replace one leaving in the same cycle
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (action == ACT_SAMPLE) begin
              frame_sum <= sum_next;
              if (frame_count != '1) begin
                frame_count <= frame_count + 1'b1;
              end
            end else begin
              frame_sum   <= '0;
              frame_count <= '0;
              state       <= (frame_count != '0) ? S_DIV1 : S_WRITE;
            end
          end
        end
        S_DIV1: begin
          if (div_sts.done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (ring_full) begin
            slot <= (slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
          end else begin
            filled <= filled + 1'b1;
          end
          rd_pend <= 1'b0;
          state   <= S_SUM;
        end
        S_SUM: begin
          rd_pend <= sum_issue;
          if (sum_finish) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_sts.done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: frame mean, read index, window total, result
  always_ff @(posedge clk) begin
    if (in_xfer && action == ACT_FRAME_END) begin
      mean <= '0;
    end else if (state == S_DIV1 && div_sts.done) begin
      mean <= (div_quo[SUM_W-1:MEAN_W] != '0) ? '1 : div_quo[MEAN_W-1:0];
    end
    if (state == S_WRITE) begin
      rd_idx <= '0;
      total  <= '0;
    end else if (state == S_SUM) begin
      if (sum_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend) begin
        total <= total + TOT_W'(ram_rdata);
      end
    end
    if (state == S_DIV2 && div_sts.done) begin
      avg <= div_quo[MEAN_W-1:0];
    end
    if (load) begin
      window_average_ns <= avg;
      has_time          <= (avg != '0);
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FILL_W'(WINDOW_DEPTH))
    else $error("ring fill count above depth");

  a_slot_full: assert property (@(posedge clk) disable iff (rst)
    (slot != '0) |-> ring_full)
    else $error("overwrite slot moved before ring filled");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_avg_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV2 && div_sts.done) |-> (div_quo[SUM_W-1:MEAN_W] == '0))
    else $error("window mean wider than result");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_time == (window_average_ns != '0)))
    else $error("has_time disagrees with average");

endmodule
